/* hw/rtl/bsc_pkg.sv */
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants of the barometric compensation pipeline.
// ----------------------------------------------------------------------------
package bsc_pkg;

  // Configuration register indexes
  localparam logic [7:0] REG_TEMP_COEFFS    = 8'd0;
  localparam logic [7:0] REG_PRESS_COEFFS_A = 8'd1;
  localparam logic [7:0] REG_PRESS_COEFFS_B = 8'd2;
  localparam logic [7:0] REG_PRESS_COEFFS_C = 8'd3;

  // Arithmetic constants of the compensation formulas
  localparam int          TFINE_OFFSET = 128000;
  localparam logic [20:0] P_BASE       = 21'd1048576;
  localparam logic [63:0] DIV_SCALE    = 64'd3125;
  localparam logic [63:0] V1_BIAS      = 64'h0000_8000_0000_0000;

  // Calibration register set
  typedef struct packed {
    logic [47:0] temp_coeffs;
    logic [47:0] press_coeffs_a;
    logic [47:0] press_coeffs_b;
    logic [47:0] press_coeffs_c;
  } coeff_regs_t;

  // Front end to divider
  typedef struct packed {
    logic signed [31:0] temp;
    logic               invalid;
    logic               neg;
    logic [63:0]        nm;
    logic [30:0]        dm;
  } div_in_t;

  // Divider to back end
  typedef struct packed {
    logic signed [31:0] temp;
    logic               invalid;
    logic               neg;
    logic [63:0]        quo;
  } div_out_t;

endpackage

/* hw/rtl/bsc_front.sv */
// ----------------------------------------------------------------------------
// bsc_front
// Temperature compensation and pressure terms up to the divider operands.
// ----------------------------------------------------------------------------
module bsc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  logic [19:0]         raw_t,
  input  logic [19:0]         raw_p,
  input  bsc_pkg::coeff_regs_t cfg,
  output logic                out_vld,
  output bsc_pkg::div_in_t    out
);

  // Coefficient fields
  logic        [15:0] t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6;
  assign t1 = cfg.temp_coeffs[15:0];
  assign t2 = cfg.temp_coeffs[31:16];
  assign t3 = cfg.temp_coeffs[47:32];
  assign p1 = cfg.press_coeffs_a[15:0];
  assign p2 = cfg.press_coeffs_a[31:16];
  assign p3 = cfg.press_coeffs_a[47:32];
  assign p4 = cfg.press_coeffs_b[15:0];
  assign p5 = cfg.press_coeffs_b[31:16];
  assign p6 = cfg.press_coeffs_b[47:32];

  logic [10:0] vld;

  logic signed [31:0] s1_a, s1_b;
  logic signed [31:0] s2_m1, s2_bb;
  logic signed [31:0] s3_tv1, s3_m2;
  logic signed [31:0] tfine;
  logic signed [32:0] s4_v1;
  logic signed [31:0] s4_temp, s5_temp, s6_temp, s7_temp, s8_temp, s9_temp, s10_temp;
  logic [19:0]        s1_p, s2_p, s3_p, s4_p, s5_p, s6_p, s7_p, s8_p;
  logic signed [65:0] sq_full;
  logic signed [63:0] s5_sq;
  logic signed [48:0] s5_a5, s5_a2, s6_a5, s6_a2;
  logic signed [63:0] s6_t6, s6_t3;
  logic signed [63:0] s7_v2, s7_v1b, s8_v2;
  logic [63:0]        s8_w;
  logic [20:0]        pdiff;
  logic [63:0]        s9_num0, s10_num;
  logic signed [30:0] s9_den, s10_den;
  logic               s9_inv, s10_inv;

  assign tfine   = s3_tv1 + (s3_m2 >>> 14);
  assign sq_full = s4_v1 * s4_v1;
  assign pdiff   = bsc_pkg::P_BASE - {1'b0, s8_p};

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[9:0], in_vld};
    end
  end

  // Temperature stages
  always_ff @(posedge clk) begin
    if (en) begin
      s1_a    <= 32'(raw_t >> 3) - (32'(t1) << 1);
      s1_b    <= 32'(raw_t >> 4) - 32'(t1);
      s1_p    <= raw_p;
      s2_m1   <= s1_a * 32'(t2);
      s2_bb   <= s1_b * s1_b;
      s2_p    <= s1_p;
      s3_tv1  <= s2_m1 >>> 11;
      s3_m2   <= (s2_bb >>> 12) * 32'(t3);
      s3_p    <= s2_p;
      s4_temp <= ((tfine <<< 2) + tfine + 32'sd128) >>> 8;
      s4_v1   <= 33'(tfine) - 33'(bsc_pkg::TFINE_OFFSET);
      s4_p    <= s3_p;
    end
  end

  // Pressure product stages
  always_ff @(posedge clk) begin
    if (en) begin
      s5_sq    <= sq_full[63:0];
      s5_a5    <= s4_v1 * p5;
      s5_a2    <= s4_v1 * p2;
      s5_temp  <= s4_temp;
      s5_p     <= s4_p;
      s6_t6    <= s5_sq * p6;
      s6_t3    <= s5_sq * p3;
      s6_a5    <= s5_a5;
      s6_a2    <= s5_a2;
      s6_temp  <= s5_temp;
      s6_p     <= s5_p;
      s7_v2    <= s6_t6 + (64'(s6_a5) <<< 17) + (64'(p4) <<< 35);
      s7_v1b   <= (s6_t3 >>> 8) + (64'(s6_a2) <<< 12);
      s7_temp  <= s6_temp;
      s7_p     <= s6_p;
      s8_w     <= (s7_v1b + bsc_pkg::V1_BIAS) * {48'd0, p1};
      s8_v2    <= s7_v2;
      s8_temp  <= s7_temp;
      s8_p     <= s7_p;
      s9_den   <= s8_w[63:33];
      s9_inv   <= (s8_w[63:33] == '0);
      s9_num0  <= {12'd0, pdiff, 31'd0} - s8_v2;
      s9_temp  <= s8_temp;
      s10_num  <= s9_num0 * bsc_pkg::DIV_SCALE;
      s10_den  <= s9_den;
      s10_inv  <= s9_inv;
      s10_temp <= s9_temp;
    end
  end

  // Split into sign and magnitudes for the divider
  always_ff @(posedge clk) begin
    if (en) begin
      out.temp    <= s10_temp;
      out.invalid <= s10_inv;
      out.neg     <= s10_num[63] ^ s10_den[30];
      out.nm      <= s10_num[63] ? (64'd0 - s10_num) : s10_num;
      out.dm      <= s10_den[30] ? (31'd0 - s10_den) : s10_den;
    end
  end

  assign out_vld = vld[10];

endmodule

/* hw/rtl/bsc_div.sv */
// ----------------------------------------------------------------------------
// bsc_div
// Pipelined restoring divider, RADIX_BITS quotient bits per stage.
// ----------------------------------------------------------------------------
module bsc_div #(
  parameter int RADIX_BITS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  bsc_pkg::div_in_t  in,
  output logic              out_vld,
  output bsc_pkg::div_out_t out
);

  localparam int STAGES = 64 / RADIX_BITS;

  typedef struct packed {
    logic signed [31:0] temp;
    logic               invalid;
    logic               neg;
    logic [30:0]        dm;
    logic [30:0]        rem;
    logic [63:0]        qn;
  } div_st_t;

  div_st_t st  [STAGES+1];
  logic    vld [STAGES+1];

  assign st[0]  = '{temp: in.temp, invalid: in.invalid, neg: in.neg,
                    dm: in.dm, rem: '0, qn: in.nm};
  assign vld[0] = in_vld;

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    div_st_t nxt;

    // Shift in numerator bits, subtract divisor where it fits
    always_comb begin
      logic [30:0] r;
      logic [63:0] q;
      logic [31:0] t;
      r = st[g].rem;
      q = st[g].qn;
      for (int k = 0; k < RADIX_BITS; k++) begin
        t = {r, q[63]};
        q = {q[62:0], 1'b0};
        if (t >= {1'b0, st[g].dm}) begin
          r    = 31'(t - {1'b0, st[g].dm});
          q[0] = 1'b1;
        end else begin
          r = t[30:0];
        end
      end
      nxt     = st[g];
      nxt.rem = r;
      nxt.qn  = q;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[g+1] <= nxt;
      end
    end
  end

  assign out_vld     = vld[STAGES];
  assign out.temp    = st[STAGES].temp;
  assign out.invalid = st[STAGES].invalid;
  assign out.neg     = st[STAGES].neg;
  assign out.quo     = st[STAGES].qn;

endmodule

/* hw/rtl/bsc_back.sv */
// ----------------------------------------------------------------------------
// bsc_back
// Second-order pressure correction and the output register.
// ----------------------------------------------------------------------------
module bsc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  bsc_pkg::div_out_t   in,
  input  logic [47:0]         press_coeffs_c,
  output logic                out_vld,
  output logic signed [31:0]  temp,
  output logic [31:0]         press,
  output logic                invalid
);

  logic signed [15:0] p7, p8, p9;
  assign p7 = press_coeffs_c[15:0];
  assign p8 = press_coeffs_c[31:16];
  assign p9 = press_coeffs_c[47:32];

  logic [3:0] vld;
  logic signed [31:0] sa_temp, sb_temp, sc_temp, sd_temp;
  logic               sa_inv, sb_inv, sc_inv, sd_inv;
  logic signed [63:0] sa_p, sb_p, sc_p;
  logic signed [63:0] sb_q, sb_m, sb_m8, sc_m8;
  logic [63:0]        sc_pp0;
  logic [31:0]        sc_pp1, sc_pp2;
  logic signed [63:0] prod, sd_sum, fin;

  assign prod = sc_pp0 + {sc_pp1 + sc_pp2, 32'd0};
  assign fin  = (sd_sum >>> 8) + (64'(p7) <<< 4);

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld     <= {vld[2:0], in_vld};
      out_vld <= vld[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // restore quotient sign
      sa_p    <= in.neg ? (64'd0 - in.quo) : in.quo;
      sa_inv  <= in.invalid;
      sa_temp <= in.temp;
      // first products
      sb_q    <= sa_p >>> 13;
      sb_m    <= p9 * (sa_p >>> 13);
      sb_m8   <= p8 * sa_p;
      sb_p    <= sa_p;
      sb_inv  <= sa_inv;
      sb_temp <= sa_temp;
      // partial products of the 64-bit square term
      sc_pp0  <= sb_m[31:0] * sb_q[31:0];
      sc_pp1  <= 32'(sb_m[31:0] * sb_q[63:32]);
      sc_pp2  <= 32'(sb_m[63:32] * sb_q[31:0]);
      sc_m8   <= sb_m8;
      sc_p    <= sb_p;
      sc_inv  <= sb_inv;
      sc_temp <= sb_temp;
      // sum of corrections
      sd_sum  <= sc_p + (prod >>> 25) + (sc_m8 >>> 19);
      sd_inv  <= sc_inv;
      sd_temp <= sc_temp;
      // output register
      temp    <= sd_temp;
      invalid <= sd_inv;
      press   <= sd_inv ? 32'd0 : fin[31:0];
    end
  end

endmodule

/* hw/rtl/barometric_sensor_compensation.sv */
// ----------------------------------------------------------------------------
// barometric_sensor_compensation
// Integer temperature and pressure compensation, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one raw temperature and one raw
//   pressure sample per transaction. Output channel (out_valid/out_ready)
//   returns temperature in 0.01 degC, pressure in Q24.8 Pa and a flag set
//   when the pressure divisor was zero (pressure then reads 0).
//   Calibration is written over the cfg channel (cfg_ready is always high)
//   while no transaction is in flight; indexes above 3 are dropped.
//   Throughput: one transaction per cycle while out_ready does not stall the
//   pipeline. The path from input accept to out_valid runs through the
//   11 front stages, the divider stages and 5 back stages.
//   Reset clears all valid bits and the calibration registers to zero.
//   When the receiver stalls, the whole pipeline holds; in_ready is high
//   whenever the output register is empty or being taken.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation #(
  parameter int DIV_RADIX_BITS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [19:0]        raw_temperature,
  input  logic [19:0]        raw_pressure,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] temperature_centi,
  output logic [31:0]        pressure_q24_8,
  output logic               pressure_invalid,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [47:0]        cfg_data
);

  bsc_pkg::coeff_regs_t cfg;
  bsc_pkg::div_in_t     front_out;
  bsc_pkg::div_out_t    div_out;
  logic                 front_vld, div_vld, en;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;

  // Decode calibration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bsc_pkg::REG_TEMP_COEFFS:    cfg.temp_coeffs    <= cfg_data;
        bsc_pkg::REG_PRESS_COEFFS_A: cfg.press_coeffs_a <= cfg_data;
        bsc_pkg::REG_PRESS_COEFFS_B: cfg.press_coeffs_b <= cfg_data;
        bsc_pkg::REG_PRESS_COEFFS_C: cfg.press_coeffs_c <= cfg_data;
        default: ;
      endcase
    end
  end

  bsc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (in_valid),
    .raw_t   (raw_temperature),
    .raw_p   (raw_pressure),
    .cfg     (cfg),
    .out_vld (front_vld),
    .out     (front_out)
  );

  bsc_div #(
    .RADIX_BITS (DIV_RADIX_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (front_vld),
    .in      (front_out),
    .out_vld (div_vld),
    .out     (div_out)
  );

  bsc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_vld         (div_vld),
    .in             (div_out),
    .press_coeffs_c (cfg.press_coeffs_c),
    .out_vld        (out_valid),
    .temp           (temperature_centi),
    .press          (pressure_q24_8),
    .invalid        (pressure_invalid)
  );

endmodule

/* hw/rtl/bsc_checker.sv */
// ----------------------------------------------------------------------------
// bsc_checker
// Port-level checks of the compensation pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module bsc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] temperature_centi,
  input logic [31:0] pressure_q24_8,
  input logic        pressure_invalid
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(temperature_centi)
      && $stable(pressure_q24_8) && $stable(pressure_invalid))
    else $error("stalled result changed");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

  // Invalid pressure reads zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && pressure_invalid |-> pressure_q24_8 == 32'd0)
    else $error("invalid pressure not zero");

  // Accept whenever the output register frees
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready mismatch");

endmodule

bind barometric_sensor_compensation bsc_checker u_bsc_checker (
  .clk               (clk),
  .rst               (rst),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .temperature_centi (temperature_centi),
  .pressure_q24_8    (pressure_q24_8),
  .pressure_invalid  (pressure_invalid)
);

/* dv/barometric_sensor_compensation_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometric_sensor_compensation_test
// Self-checking bench for the temperature and pressure compensation pipeline.
// The calibration is written over the cfg channel in phases: reset values, a
// typical sensor set, a zero divisor, the extremes and random sets. Raw sample
// pairs are driven with random gaps. Every accepted pair is run through a
// local integer model of the compensation, and each returned transaction is
// compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation_test;

  typedef struct {
    logic signed [31:0] temp;
    logic [31:0]        press;
    logic               inv;
  } reading_t;

  // Scoreboard: calibration copy, compensation model and pending readings
  class reading_scoreboard;
    logic [47:0] coeff [4];
    reading_t    pending_q[$];
    int          errors;

    function new();
      foreach (coeff[i]) coeff[i] = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [7:0] idx, logic [47:0] data);
      case (idx)
        bsc_pkg::REG_TEMP_COEFFS:    coeff[0] = data;
        bsc_pkg::REG_PRESS_COEFFS_A: coeff[1] = data;
        bsc_pkg::REG_PRESS_COEFFS_B: coeff[2] = data;
        bsc_pkg::REG_PRESS_COEFFS_C: coeff[3] = data;
        default: ;
      endcase
    endfunction

    function reading_t compensate(logic [19:0] rt, logic [19:0] rp);
      logic signed [31:0] t1, t2, t3, a, b, tv1, tv2, tf;
      logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic signed [63:0] v1, v2, p, q, num;
      logic [63:0] nm, dm, uq;
      reading_t r;
      t1 = $signed({16'd0, coeff[0][15:0]});
      t2 = $signed(coeff[0][31:16]);
      t3 = $signed(coeff[0][47:32]);
      p1 = $signed({48'd0, coeff[1][15:0]});
      p2 = $signed(coeff[1][31:16]);
      p3 = $signed(coeff[1][47:32]);
      p4 = $signed(coeff[2][15:0]);
      p5 = $signed(coeff[2][31:16]);
      p6 = $signed(coeff[2][47:32]);
      p7 = $signed(coeff[3][15:0]);
      p8 = $signed(coeff[3][31:16]);
      p9 = $signed(coeff[3][47:32]);
      // temperature path, 32-bit wrapping
      a   = $signed({12'd0, rt} >> 3) - (t1 <<< 1);
      tv1 = (a * t2) >>> 11;
      b   = $signed({12'd0, rt} >> 4) - t1;
      tv2 = (((b * b) >>> 12) * t3) >>> 14;
      tf  = tv1 + tv2;
      r.temp = (tf * 5 + 128) >>> 8;
      // pressure path, 64-bit wrapping
      v1 = tf - 64'sd128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) <<< 17);
      v2 = v2 + (p4 <<< 35);
      v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
      v1 = ((64'sh0000_8000_0000_0000 + v1) * p1) >>> 33;
      if (v1 == 0) begin
        r.press = '0;
        r.inv = 1'b1;
      end else begin
        p   = 64'sd1048576 - $signed({44'd0, rp});
        num = ((p <<< 31) - v2) * 64'sd3125;
        nm  = num[63] ? -num : num;
        dm  = v1[63] ? -v1 : v1;
        uq  = nm / dm;
        p   = (num[63] ^ v1[63]) ? -uq : uq;
        q   = p >>> 13;
        v1  = (p9 * q * q) >>> 25;
        v2  = (p8 * p) >>> 19;
        p   = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
        r.press = p[31:0];
        r.inv = 1'b0;
      end
      return r;
    endfunction

    function void note_sample(logic [19:0] rt, logic [19:0] rp);
      pending_q.push_back(compensate(rt, rp));
    endfunction

    function void check_reading(logic signed [31:0] t, logic [31:0] p, logic inv);
      reading_t e;
      if (pending_q.size() == 0) begin
        errors++;
        $error("unexpected reading temp=%0d press=%h inv=%b", t, p, inv);
      end else begin
        e = pending_q.pop_front();
        if (t !== e.temp) begin
          errors++;
          $error("temperature_centi expected %0d actual %0d", e.temp, t);
        end
        if (p !== e.press) begin
          errors++;
          $error("pressure_q24_8 expected %h actual %h", e.press, p);
        end
        if (inv !== e.inv) begin
          errors++;
          $error("pressure_invalid expected %b actual %b", e.inv, inv);
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [19:0]        raw_temperature = '0;
  logic [19:0]        raw_pressure = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] temperature_centi;
  logic [31:0]        pressure_q24_8;
  logic               pressure_invalid;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [7:0]         cfg_index = '0;
  logic [47:0]        cfg_data = '0;

  reading_scoreboard sb = new();
  bit steady = 1'b0;       // no idling on either side
  bit hold_req = 1'b0;     // ask the receiver for a long hold-off
  int hold_cnt = 0;

  barometric_sensor_compensation u_dut (.*);

  // Generate clock
  initial begin
    forever #2 clk = ~clk;
  end

  // Bound the run
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Drive out_ready with random stalls and the occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_ready <= 1'b0;
      hold_cnt = hold_cnt - 1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = 300;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 23);
    end
  end

  // Check each output transaction; signals are stable at the falling edge
  always @(negedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_reading(temperature_centi, pressure_q24_8, pressure_invalid);
  end

  task automatic write_reg(logic [7:0] idx, logic [47:0] data);
    bit rdy;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    sb.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(logic [19:0] rt, logic [19:0] rp);
    bit rdy;
    while (!steady && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    raw_temperature <= rt;
    raw_pressure    <= rp;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    sb.note_sample(rt, rp);
  endtask

  // Wait out every pending reading plus the pipeline depth
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  // Calibration set: typical, zero P1, extremes, typical with jitter or fully random
  task automatic load_calibration(int mode);
    logic [47:0] c [4];
    case (mode)
      0: begin
        c[0] = {16'hFC18, 16'd26435, 16'd27504};
        c[1] = {16'd3024, 16'hD643, 16'd36477};
        c[2] = {16'hFFF9, 16'd140, 16'd2855};
        c[3] = {16'd6000, 16'hC6F8, 16'd15500};
      end
      1: begin
        c[0] = {16'hFC18, 16'd26435, 16'd27504};
        c[1] = {16'd3024, 16'hD643, 16'd0};
        c[2] = rand48();
        c[3] = rand48();
      end
      2: foreach (c[i]) c[i] = '1;
      3: foreach (c[i]) c[i] = {3{16'h8000}};
      4: foreach (c[i]) c[i] = {3{16'h7FFF}};
      5: begin
        c[0] = {16'hFC18 + 16'($urandom_range(64)), 16'd26435 + 16'($urandom_range(500)),
                16'd27504 + 16'($urandom_range(500))};
        c[1] = {16'd3024 + 16'($urandom_range(64)), 16'hD643 + 16'($urandom_range(500)),
                16'd36477 + 16'($urandom_range(500))};
        c[2] = {16'hFFF9, 16'd140 + 16'($urandom_range(20)), 16'd2855 + 16'($urandom_range(99))};
        c[3] = {16'd6000 + 16'($urandom_range(99)), 16'hC6F8, 16'd15500 + 16'($urandom_range(99))};
      end
      default: foreach (c[i]) c[i] = rand48();
    endcase
    write_reg(bsc_pkg::REG_TEMP_COEFFS, c[0]);
    write_reg(bsc_pkg::REG_PRESS_COEFFS_A, c[1]);
    write_reg(bsc_pkg::REG_PRESS_COEFFS_B, c[2]);
    write_reg(bsc_pkg::REG_PRESS_COEFFS_C, c[3]);
    // out-of-range indexes must be dropped
    write_reg(8'd4 + 8'($urandom_range(251)), rand48());
  endtask

  task automatic random_samples(int n, bit typical);
    logic [19:0] rt, rp;
    for (int i = 0; i < n; i++) begin
      if (typical && $urandom_range(99) < 80) begin
        rt = 20'd519888 + 20'($urandom_range(60000)) - 20'd30000;
        rp = 20'd415148 + 20'($urandom_range(200000)) - 20'd100000;
      end else begin
        rt = 20'($urandom);
        rp = 20'($urandom);
      end
      send_sample(rt, rp);
      if (i == n / 2 && $urandom_range(1)) begin
        // let the pipeline empty with the sender quiet
        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge clk);
      end
    end
    drain();
  endtask

  // Main sequence
  initial begin
    int mode;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset calibration: zero divisor
    send_sample(20'd0, 20'd0);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'd519888, 20'd415148);
    drain();

    // Typical set, field extremes
    load_calibration(0);
    send_sample(20'd0, 20'd0);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'd0, 20'hFFFFF);
    send_sample(20'hFFFFF, 20'd0);
    send_sample(20'd519888, 20'd415148);
    send_sample(20'h55555, 20'hAAAAA);
    send_sample(20'hAAAAA, 20'h55555);
    drain();

    // Zero P1: divisor forced to zero
    load_calibration(1);
    send_sample(20'd519888, 20'd415148);
    send_sample(20'hFFFFF, 20'd0);
    drain();

    for (int ph = 2; ph < 14; ph++) begin
      mode = (ph < 5) ? ph : (ph % 3 == 0) ? 6 : 5;
      load_calibration(mode);
      if (ph == 5) begin
        steady = 1'b1;
      end else begin
        steady = 1'b0;
      end
      if (ph == 6) hold_req = 1'b1;
      random_samples((ph < 5) ? 40 : 150, mode != 6);
    end

    steady = 1'b0;
    drain();
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
